/* rtl/wbm_pkg.sv */
// Package for the windowed bitrate meter: widths, constants, the controller
// state type and the command and status words between controller and datapath.
// No dependencies.
package wbm_pkg;

    // Field widths.
    localparam int TIME_W  = 64;
    localparam int BYTES_W = 32;
    localparam int AVG_W   = 32;
    localparam int TOTAL_W = 64;
    localparam int MCAND_W = 32;                       // multiplier operand slice
    localparam int SCALE_W = 20;                       // width of one million
    localparam int PPART_W = MCAND_W + SCALE_W;        // partial product
    localparam int PROD_W  = TOTAL_W + SCALE_W;        // full scaled product
    localparam int CNT_W   = $clog2(AVG_W);

    // Configuration port.
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam logic [APB_AW-1:0] ADDR_WINDOW_LEN = 3'd0;

    // Arithmetic constants.
    localparam logic [SCALE_W-1:0] US_PER_SECOND  = 20'd1000000;
    localparam int                 BYTE_SHIFT     = 3;   // eight bits per byte
    localparam logic [31:0]        WINDOW_LEN_RST = 32'd1000000;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_CHECK,
        ST_DIV,
        ST_FIN,
        ST_WRITE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic capture;
        logic eval;
        logic mul_lo;
        logic mul_hi;
        logic check;
        logic div_step;
        logic close;
        logic load_out;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic close_win;
        logic over;
        logic div_last;
    } t_dp_stat;

endpackage

/* rtl/wbm_regs.sv */
// Configuration register file of the windowed bitrate meter, on an APB port.
// Depends on wbm_pkg.
module wbm_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wbm_pkg::APB_AW-1:0] paddr,
    input  logic [wbm_pkg::APB_DW-1:0] pwdata,
    output logic [wbm_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [31:0]                o_window_len
);
    import wbm_pkg::*;

    logic [31:0] r_window_len;
    logic        hit;

    // Registers are word aligned; the low address bits are ignored.
    assign hit    = (paddr[APB_AW-1:2] == ADDR_WINDOW_LEN[APB_AW-1:2]);
    assign pready = 1'b1;

    // Write on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_LEN_RST;
        end else if (psel && penable && pwrite && pready && hit) begin
            r_window_len <= pwdata;
        end
    end

    // Read back.
    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata = r_window_len;
        end
    end

    assign o_window_len = r_window_len;

endmodule

/* rtl/wbm_ctrl.sv */
// Controller of the windowed bitrate meter: sequences one packet word through
// evaluation, scaling multiply and the bit-serial divide. Depends on wbm_pkg.
module wbm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  wbm_pkg::t_dp_stat i_stat,
    output wbm_pkg::t_dp_cmd  o_cmd
);
    import wbm_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   slot_free;

    // The output register can take a word when empty or being drained.
    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_EVAL;
            ST_EVAL:   n_state = i_stat.close_win ? ST_MUL_LO : ST_WRITE;
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_CHECK;
            ST_CHECK:  n_state = i_stat.over ? ST_FIN : ST_DIV;
            ST_DIV:    if (i_stat.div_last) n_state = ST_FIN;
            ST_FIN:    n_state = ST_WRITE;
            ST_WRITE:  if (slot_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EVAL:   o_cmd.eval     = 1'b1;
            ST_MUL_LO: o_cmd.mul_lo   = 1'b1;
            ST_MUL_HI: o_cmd.mul_hi   = 1'b1;
            ST_CHECK:  o_cmd.check    = 1'b1;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_FIN:    o_cmd.close    = 1'b1;
            ST_WRITE:  o_cmd.load_out = slot_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/wbm_dp.sv */
// Datapath of the windowed bitrate meter: window state, saturating bit total,
// shared 32x20 scaling multiplier, restoring divider and the output register.
// Depends on wbm_pkg.
module wbm_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wbm_pkg::t_dp_cmd            i_cmd,
    output wbm_pkg::t_dp_stat           o_stat,
    input  logic [wbm_pkg::TIME_W-1:0]  i_time,
    input  logic [wbm_pkg::BYTES_W-1:0] i_bytes,
    input  logic [31:0]                 i_window_len,
    output logic [wbm_pkg::AVG_W-1:0]   o_avg,
    output logic                        o_updated
);
    import wbm_pkg::*;

    // Captured packet.
    logic [TIME_W-1:0]  r_now;
    logic [BYTES_W-1:0] r_bytes;
    // Window state.
    logic [TIME_W-1:0]  r_start;
    logic [TOTAL_W-1:0] r_total;
    logic [AVG_W-1:0]   r_last;
    logic               r_upd;
    // Working registers.
    logic [TIME_W-1:0]  r_elapsed;
    logic [PROD_W-1:0]  r_prod;
    logic [TOTAL_W-1:0] r_rem;
    logic [AVG_W-1:0]   r_q;
    logic [CNT_W-1:0]   r_cnt;
    // Output register.
    logic [AVG_W-1:0]   r_out_avg;
    logic               r_out_upd;

    logic               restart;
    logic [TIME_W-1:0]  elapsed;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] sat_sum;
    logic [MCAND_W-1:0] mul_in;
    logic [PPART_W-1:0] mul_out;
    logic [TOTAL_W:0]   shifted;
    logic [TOTAL_W:0]   diff;
    logic               ge;
    logic               over;

    // Window decision for the captured packet.
    assign restart = (r_start == '0) || (r_now <= r_start);
    assign elapsed = r_now - r_start;
    assign sum     = {1'b0, r_total}
                   + (TOTAL_W+1)'({r_bytes, BYTE_SHIFT'(0)});
    assign sat_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

    // Shared multiplier: one 32-bit half of the bit total per cycle.
    assign mul_in  = i_cmd.mul_hi ? r_total[TOTAL_W-1:MCAND_W] : r_total[MCAND_W-1:0];
    assign mul_out = PPART_W'(mul_in) * PPART_W'(US_PER_SECOND);

    // Saturation test: the quotient fits 32 bits only if the upper product
    // bits stay below the elapsed time.
    assign over = (TOTAL_W'(r_prod[PROD_W-1:AVG_W]) >= r_elapsed);

    // One restoring divide step.
    assign shifted = {r_rem, r_q[AVG_W-1]};
    assign diff    = shifted - {1'b0, r_elapsed};
    assign ge      = (shifted >= {1'b0, r_elapsed});

    assign o_stat.close_win = !restart && (elapsed >= TIME_W'(i_window_len));
    assign o_stat.over      = over;
    assign o_stat.div_last  = (r_cnt == CNT_W'(AVG_W - 1));

    // Window state and last average.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_total <= '0;
            r_last  <= '0;
            r_upd   <= 1'b0;
        end else if (i_cmd.eval) begin
            r_upd <= 1'b0;
            if (restart) begin
                r_start <= r_now;
                r_total <= '0;
            end else begin
                r_total <= sat_sum;
            end
        end else if (i_cmd.close) begin
            r_last  <= r_q;
            r_start <= r_now;
            r_total <= '0;
            r_upd   <= 1'b1;
        end
    end

    // Packet capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now   <= i_time;
            r_bytes <= i_bytes;
        end
    end

    // Scaling multiply and divide.
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_elapsed <= elapsed;
        end
        if (i_cmd.mul_lo) begin
            r_prod <= PROD_W'(mul_out);
        end else if (i_cmd.mul_hi) begin
            r_prod <= r_prod + {mul_out, MCAND_W'(0)};
        end
        if (i_cmd.check) begin
            r_rem <= TOTAL_W'(r_prod[PROD_W-1:AVG_W]);
            r_q   <= over ? '1 : r_prod[AVG_W-1:0];
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
            r_q   <= {r_q[AVG_W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_avg <= r_last;
            r_out_upd <= r_upd;
        end
    end

    assign o_avg     = r_out_avg;
    assign o_updated = r_out_upd;

endmodule

/* rtl/windowed_bitrate_meter.sv */
// Top level of the windowed bitrate meter: configuration registers, controller
// and datapath. Depends on wbm_pkg, wbm_regs, wbm_ctrl and wbm_dp.
//
//  Channel   Direction  Handshake          Content
//  s_*       in         s_tvalid/s_tready  packet_time_us, packet_bytes
//  m_*       out        m_tvalid/m_tready  average_bps; tuser average_updated
//  APB       in/out     psel/penable       window_length_us at address 0
//
// A packet word passes through evaluation alone when no window closes, adds the
// scaling multiply when one closes with a saturated average, and adds the 32
// steps of the bit-serial divider when one closes otherwise.
// One packet is handled at a time; the next is taken once the result is in
// the output register, which may still wait on m_tready.
// Reset is synchronous and active low; it closes the window and loads the
// default window length of one second.
module windowed_bitrate_meter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Packet words.
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [95:0]                s_tdata,   // [63:0] packet_time_us,
                                                  // [95:64] packet_bytes
    // Result words.
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // [31:0] average_bps
    output logic [0:0]                 m_tuser,   // [0] average_updated
    // Configuration.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wbm_pkg::APB_AW-1:0] paddr,
    input  logic [wbm_pkg::APB_DW-1:0] pwdata,
    output logic [wbm_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import wbm_pkg::*;

    logic [31:0] window_len;
    t_dp_cmd     cmd;
    t_dp_stat    stat;
    logic        updated;

    // Configuration registers.
    wbm_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_window_len (window_len)
    );

    // Sequencer.
    wbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Arithmetic and window state.
    wbm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_time       (s_tdata[TIME_W-1:0]),
        .i_bytes      (s_tdata[TIME_W+BYTES_W-1:TIME_W]),
        .i_window_len (window_len),
        .o_avg        (m_tdata),
        .o_updated    (updated)
    );

    assign m_tuser[0] = updated;

endmodule

/* sim/windowed_bitrate_meter_tb.sv */
// Self-checking testbench for windowed_bitrate_meter: streams packet reports, predicts
// every average word and checks the results against that prediction across window lengths.
// Depends on wbm_pkg and the windowed_bitrate_meter RTL.
`timescale 1ns / 100ps
module windowed_bitrate_meter_tb;

    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_CYCLES  = 60;
    localparam logic [63:0] MICROS_PER_S  = 64'd1_000_000;
    localparam logic [31:0] DEFAULT_LEN   = 32'd1_000_000;
    localparam logic [31:0] AVERAGE_SAT   = 32'hFFFF_FFFF;

    // One packet report; the packed layout matches the input word.
    typedef struct packed {
        logic [31:0] bytes;
        logic [63:0] time_us;
    } t_packet;

    // One expected result word.
    typedef struct packed {
        logic [31:0] average_bps;
        logic        updated;
    } t_average;

    logic                               i_clk   = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [95:0]                        s_tdata  = '0;  // [63:0] packet_time_us,
                                                        // [95:64] packet_bytes
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [31:0]                        m_tdata;        // [31:0] average_bps
    logic [0:0]                         m_tuser;        // [0] average_updated
    logic                               psel     = 1'b0;
    logic                               penable  = 1'b0;
    logic                               pwrite   = 1'b0;
    logic [wbm_pkg::APB_AW-1:0]         paddr    = '0;
    logic [wbm_pkg::APB_DW-1:0]         pwdata   = '0;
    logic [wbm_pkg::APB_DW-1:0]         prdata;
    logic                               pready;

    // Stimulus and expectation stores.
    t_packet  packet_backlog[$];
    t_average pending_averages[$];

    // Predictor state.
    logic [31:0] mdl_window  = DEFAULT_LEN;
    logic [63:0] mdl_start   = '0;
    logic [63:0] mdl_bits    = '0;
    logic [31:0] mdl_average = '0;

    // Traffic generator and handshake pacing.
    logic [63:0] gen_time   = '0;
    logic        quiet_tail = 1'b0;
    logic        hold_req   = 1'b0;
    int          hold_cnt   = 0;
    int          send_gap   = 0;
    int          recv_gap   = 0;
    int          mismatches = 0;

    windowed_bitrate_meter u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Prints one line per mismatch and counts it.
    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Advances the meter state by one packet and stores the word it must produce.
    task automatic predict_average(input t_packet pkt);
        logic [63:0]  add_bits;
        logic [63:0]  elapsed;
        logic [127:0] quotient;
        t_average     res;
        add_bits    = {29'd0, pkt.bytes, 3'd0};
        res.updated = 1'b0;
        if (mdl_start == 64'd0 || pkt.time_us <= mdl_start) begin
            // No open window or time did not advance: restart without counting.
            mdl_start = pkt.time_us;
            mdl_bits  = '0;
        end else begin
            // The bit total saturates instead of wrapping.
            if (mdl_bits > ~add_bits) begin
                mdl_bits = '1;
            end else begin
                mdl_bits = mdl_bits + add_bits;
            end
            elapsed = pkt.time_us - mdl_start;
            if (elapsed >= {32'd0, mdl_window}) begin
                quotient    = ({64'd0, mdl_bits} * {64'd0, MICROS_PER_S}) / {64'd0, elapsed};
                mdl_average = (quotient > {96'd0, AVERAGE_SAT}) ? AVERAGE_SAT : quotient[31:0];
                mdl_start   = pkt.time_us;
                mdl_bits    = '0;
                res.updated = 1'b1;
            end
        end
        res.average_bps = mdl_average;
        pending_averages.push_back(res);
    endtask

    task automatic queue_packet(input logic [63:0] time_us, input logic [31:0] bytes);
        t_packet pkt;
        pkt.time_us = time_us;
        pkt.bytes   = bytes;
        gen_time    = time_us;
        packet_backlog.push_back(pkt);
    endtask

    // Mostly advancing timestamps scaled to the window, with repeats, steps back,
    // zero times and random jumps mixed in.
    task automatic queue_traffic(input int count);
        logic [63:0] step_max;
        logic [63:0] t;
        logic [31:0] bytes;
        for (int n = 0; n < count; n++) begin
            step_max = {33'd0, mdl_window[31:1]} + 64'd1;
            t        = gen_time;
            case ($urandom_range(0, 19))
                0: t = gen_time;
                1: if (t != 64'd0) t = t - 64'd1 - ({32'd0, $urandom} % t);
                2: t = {$urandom, $urandom};
                3: t = '0;
                default: t = t + 64'd1 + ({$urandom, $urandom} % step_max);
            endcase
            case ($urandom_range(0, 3))
                0: bytes = $urandom;
                1: bytes = $urandom_range(0, 1500);
                2: bytes = $urandom_range(0, 65535);
                default: bytes = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            endcase
            queue_packet(t, bytes);
        end
    endtask

    // Blocks until every queued packet has gone in and every result has come out.
    task automatic wait_for_drain();
        while (packet_backlog.size() != 0 || s_tvalid || pending_averages.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes the window length over the configuration port and reads it back.
    task automatic set_window_length(input logic [31:0] length_us);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= wbm_pkg::ADDR_WINDOW_LEN;
        pwdata  <= length_us;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        mdl_window = length_us;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== length_us) begin
            flag_mismatch($sformatf("window length read %0h, wrote %0h", prdata, length_us));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Packet driver: predicts each accepted word and offers the next from the backlog.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_average(t_packet'(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (packet_backlog.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= $urandom_range(0, 3);
                end else begin
                    s_tdata  <= packet_backlog.pop_front();
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (hold_req) begin
            hold_cnt <= HOLD_CYCLES;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Result monitor: compares each accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        t_average exp_word;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_averages.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result %0h", m_tdata));
                end else begin
                    exp_word = pending_averages.pop_front();
                    if (m_tdata !== exp_word.average_bps) begin
                        flag_mismatch($sformatf("average_bps %0d, expected %0d",
                                                m_tdata, exp_word.average_bps));
                    end
                    if (m_tuser[0] !== exp_word.updated) begin
                        flag_mismatch($sformatf("average_updated %0b, expected %0b",
                                                m_tuser[0], exp_word.updated));
                    end
                end
            end
            if (hold_req || hold_cnt != 0) begin
                m_tready <= 1'b0;
            end else if (recv_gap != 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                recv_gap <= $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        for (int cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
            @(posedge i_clk);
        end
        $display("windowed_bitrate_meter regression: fail");
        $finish;
    end

    // Test sequence.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window length of one second.
        queue_packet(64'd0, 32'd0);                   // zero time keeps the window closed
        queue_packet(64'd0, 32'hFFFF_FFFF);
        queue_packet(64'd10, 32'hFFFF_FFFF);          // opens, bits not counted
        queue_packet(64'd10, 32'd100);                // time repeats: restart
        queue_packet(64'd5, 32'd100);                 // time steps back: restart
        queue_packet(64'd500_005, 32'hFFFF_FFFF);     // still inside the window
        queue_packet(64'd1_000_005, 32'd1);           // exactly one window: saturates
        queue_packet(64'd2_000_005, 32'd0);           // closes with no bits
        queue_packet(64'd3_000_004, 32'd125);         // one short of the window
        queue_packet(64'd3_000_005, 32'd0);           // closes at 1000 bit/s
        queue_packet(64'hFFFF_FFFF_FFFF_FFFE, 32'd1); // huge elapsed time
        queue_packet(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        queue_packet(64'd0, 32'd0);                   // back to a closed window
        queue_traffic(250);
        wait_for_drain();

        // Shortest window: every advancing packet closes it.
        set_window_length(32'd1);
        queue_packet(64'd1, 32'd0);
        queue_packet(64'd2, 32'hFFFF_FFFF);
        queue_packet(64'd3, 32'd1);
        queue_packet(64'd7, 32'd3);
        queue_traffic(250);
        // Stall the output while the sender keeps offering packets.
        while (packet_backlog.size() > 240) @(posedge i_clk);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        wait_for_drain();

        // Longest window, closed exactly at its length.
        set_window_length(32'hFFFF_FFFF);
        queue_packet(64'h0001_0000_0000_0000, 32'd200);
        queue_packet(64'h0001_0000_0000_0000, 32'd0);
        queue_packet(64'h0001_0000_FFFF_FFFE, 32'd1000);
        queue_packet(64'h0001_0000_FFFF_FFFF, 32'd10);
        queue_traffic(250);
        wait_for_drain();

        // Short random window, with a full pause in the middle.
        set_window_length($urandom_range(1, 5000));
        queue_traffic(120);
        wait_for_drain();
        queue_traffic(130);
        wait_for_drain();

        // Arbitrary window length.
        set_window_length($urandom);
        queue_traffic(250);
        wait_for_drain();

        set_window_length(DEFAULT_LEN);
        queue_traffic(200);
        wait_for_drain();

        // Last stretch runs back to back on both sides.
        quiet_tail <= 1'b1;
        set_window_length($urandom_range(2, 64));
        queue_traffic(300);
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("windowed_bitrate_meter regression: pass");
        end else begin
            $display("windowed_bitrate_meter regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/wbm_pkg.sv
rtl/wbm_regs.sv
rtl/wbm_ctrl.sv
rtl/wbm_dp.sv
rtl/windowed_bitrate_meter.sv
sim/windowed_bitrate_meter_tb.sv
